@@ hw/rtl/ymdp_pkg.sv @@
// Shared types, status codes and character constants for the year-month duration parser.
package ymdp_pkg;

    localparam int CHAR_W   = 8;
    localparam int ACC_W    = 32;
    localparam int STATUS_W = 4;
    localparam int TOTAL_W  = 31;
    localparam int YEAR_W   = 28;
    localparam int MONTH_W  = 4;
    // Width of years * 12 + months before range check
    localparam int SUM_W    = ACC_W + 4;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = status_t'(0);
    localparam status_t ST_EMPTY     = status_t'(1);
    localparam status_t ST_NO_P      = status_t'(2);
    localparam status_t ST_NO_COMP_P = status_t'(3);
    localparam status_t ST_T         = status_t'(4);
    localparam status_t ST_D         = status_t'(5);
    localparam status_t ST_UNTERM    = status_t'(6);
    localparam status_t ST_BAD_UNIT  = status_t'(7);
    localparam status_t ST_EXPECT_M  = status_t'(8);
    localparam status_t ST_NONE      = status_t'(9);
    localparam status_t ST_TRAILING  = status_t'(10);
    localparam status_t ST_OVERFLOW  = status_t'(11);

    localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_Y     = 8'h59;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [SUM_W-1:0] MAX_TOTAL = SUM_W'(64'd2147483647);

    // ceil(2^33 / 3): exact quotient by three for any operand below 2^32
    localparam logic [31:0] RECIP_3 = 32'hAAAAAAAB;
    localparam int          RECIP_SHIFT = 33;

endpackage

@@ hw/rtl/year_month_duration_parser_core.sv @@
// Streaming parser for -PnYnM year-month durations, one character per item.
//
// Usage: the s_ channel carries one character of the text per item (s_ch),
// with s_has_char low on an item that carries no character and s_is_last high
// on the final item of a text. A lone item with s_has_char low and s_is_last
// high stands for an empty text. Each text yields exactly one result item on
// the m_ channel, taken from its last item; all other items yield nothing.
// Both channels use valid/ready; an item moves when valid and ready are high.
// Path: a result passes from the input register through the capture of the
// finished text, the total and range check and the divide by twelve via
// reciprocal multiply to the output register.
// Throughput: one item per cycle while no last item waits for room, set by
// the combinational parser step (one decimal shift-add on a 32-bit accumulator per character).
// Stall: the result pipeline holds while m_ready is low; bubbles between
// stages are squeezed out. Items that are not last never wait; a last item
// waits while every result stage is full, and s_ready is low meanwhile.
// Reset: aresetn (synchronous, active low) empties every stage and returns
// the parser to the start of text with all accumulators and flags clear.
module year_month_duration_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // character items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ymdp_pkg::CHAR_W-1:0]   s_ch,
    input  logic                          s_has_char,
    input  logic                          s_is_last,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ymdp_pkg::STATUS_W-1:0] m_status,
    output logic                          m_negative,
    output logic [ymdp_pkg::TOTAL_W-1:0]  m_month_total,
    output logic [ymdp_pkg::YEAR_W-1:0]   m_year_part,
    output logic [ymdp_pkg::MONTH_W-1:0]  m_month_part
);

    typedef enum logic [3:0] {
        PH_START,
        PH_SIGN,
        PH_NOP,
        PH_AFTER_P,
        PH_NUM1,
        PH_AFTER_Y,
        PH_NUM2,
        PH_DONE,
        PH_ERR
    } phase_t;

    localparam int ACC_W   = ymdp_pkg::ACC_W;
    localparam int SUM_W   = ymdp_pkg::SUM_W;
    localparam int TOTAL_W = ymdp_pkg::TOTAL_W;
    localparam int YEAR_W  = ymdp_pkg::YEAR_W;
    localparam int DIV_W   = TOTAL_W - 2;
    localparam int PROD_W  = DIV_W + 32;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                        in_valid_reg;
    logic [ymdp_pkg::CHAR_W-1:0] in_ch_reg;
    logic                        in_has_char_reg;
    logic                        in_is_last_reg;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t                     phase_reg,      phase_next;
    logic                       sign_reg,       sign_next;
    logic [ACC_W-1:0]           number_acc_reg, number_acc_next;
    logic [ACC_W-1:0]           years_acc_reg,  years_acc_next;
    logic [ACC_W-1:0]           months_acc_reg, months_acc_next;
    logic                       acc_ovf_reg,    acc_ovf_next;
    logic                       seen_t_reg,     seen_t_next;
    logic                       seen_d_reg,     seen_d_next;
    ymdp_pkg::status_t          first_err_reg,  first_err_next;

    // Values after taking the current character, before the end-of-text clear
    phase_t                     ph_upd;
    logic                       sign_upd;
    logic [ACC_W-1:0]           num_upd;
    logic [ACC_W-1:0]           yrs_upd;
    logic [ACC_W-1:0]           mon_upd;
    logic                       ovf_upd;
    logic                       t_upd;
    logic                       d_upd;
    ymdp_pkg::status_t          err_upd;
    ymdp_pkg::status_t          end_status;

    logic                       is_digit;
    logic [3:0]                 digit_val;
    logic [ACC_W-1:0]           acc_base;
    logic [SUM_W-1:0]           acc_prod;
    logic                       acc_sat;
    logic [ACC_W-1:0]           acc_new;
    logic                       after_p;

    // ------------------------------------------------------------------
    // Result pipeline
    // ------------------------------------------------------------------
    logic                       r1_valid_reg;
    ymdp_pkg::status_t          r1_status_reg;
    logic                       r1_sign_reg;
    logic [ACC_W-1:0]           r1_years_reg;
    logic [ACC_W-1:0]           r1_months_reg;
    logic                       r1_ovf_reg;

    logic                       r2_valid_reg;
    ymdp_pkg::status_t          r2_status_reg, r2_status_next;
    logic                       r2_neg_reg,    r2_neg_next;
    logic [TOTAL_W-1:0]         r2_total_reg,  r2_total_next;
    logic [SUM_W-1:0]           sum_total;

    logic                       r3_valid_reg;
    ymdp_pkg::status_t          r3_status_reg;
    logic                       r3_neg_reg;
    logic [TOTAL_W-1:0]         r3_total_reg;
    logic [YEAR_W-1:0]          r3_quot_reg;
    logic [PROD_W-1:0]          div_prod;

    logic                       m_valid_reg;
    ymdp_pkg::status_t          m_status_reg;
    logic                       m_neg_reg;
    logic [TOTAL_W-1:0]         m_total_reg;
    logic [YEAR_W-1:0]          m_year_reg;
    logic [ymdp_pkg::MONTH_W-1:0] m_month_reg;
    logic [TOTAL_W-1:0]         rem_full;

    // Ready chain: each stage takes a new item when empty or when draining
    logic                       out_ready;
    logic                       r3_ready;
    logic                       r2_ready;
    logic                       r1_ready;
    logic                       take_item;

    assign out_ready = !m_valid_reg || m_ready;
    assign r3_ready  = !r3_valid_reg || out_ready;
    assign r2_ready  = !r2_valid_reg || r3_ready;
    assign r1_ready  = !r1_valid_reg || r2_ready;
    // A last item needs room in the result pipeline; others never wait
    assign take_item = in_valid_reg && (!in_is_last_reg || r1_ready);
    assign s_ready   = !in_valid_reg || take_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready) begin
            in_ch_reg       <= s_ch;
            in_has_char_reg <= s_has_char;
            in_is_last_reg  <= s_is_last;
        end
    end

    // ------------------------------------------------------------------
    // Parser step: decimal shift-add, phase advance, end status
    // ------------------------------------------------------------------
    assign is_digit  = (in_ch_reg >= ymdp_pkg::CH_ZERO) && (in_ch_reg <= ymdp_pkg::CH_NINE);
    assign digit_val = in_ch_reg[3:0];
    // A number starts fresh from the phase that precedes it
    assign acc_base  = (phase_reg == PH_NUM1 || phase_reg == PH_NUM2) ? number_acc_reg : '0;
    assign acc_prod  = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
                     + {{(SUM_W-4){1'b0}}, digit_val};
    assign acc_sat   = (acc_prod[SUM_W-1:ACC_W] != '0);
    assign acc_new   = acc_sat ? '1 : acc_prod[ACC_W-1:0];
    assign after_p   = (phase_reg != PH_START) && (phase_reg != PH_SIGN)
                    && (phase_reg != PH_NOP);

    always_comb begin
        ph_upd   = phase_reg;
        sign_upd = sign_reg;
        num_upd  = number_acc_reg;
        yrs_upd  = years_acc_reg;
        mon_upd  = months_acc_reg;
        ovf_upd  = acc_ovf_reg;
        t_upd    = seen_t_reg;
        d_upd    = seen_d_reg;
        err_upd  = first_err_reg;

        if (in_has_char_reg) begin
            // T and D anywhere after P are sticky
            if (after_p && in_ch_reg == ymdp_pkg::CH_T) begin
                t_upd = 1'b1;
            end
            if (after_p && in_ch_reg == ymdp_pkg::CH_D) begin
                d_upd = 1'b1;
            end
            unique case (phase_reg)
                PH_START: begin
                    if (in_ch_reg == ymdp_pkg::CH_MINUS) begin
                        sign_upd = 1'b1;
                        ph_upd   = PH_SIGN;
                    end else if (in_ch_reg == ymdp_pkg::CH_P) begin
                        ph_upd = PH_AFTER_P;
                    end else begin
                        ph_upd = PH_NOP;
                    end
                end
                PH_SIGN: begin
                    ph_upd = (in_ch_reg == ymdp_pkg::CH_P) ? PH_AFTER_P : PH_NOP;
                end
                PH_AFTER_P, PH_AFTER_Y: begin
                    if (is_digit) begin
                        num_upd = acc_new;
                        ovf_upd = acc_ovf_reg | acc_sat;
                        ph_upd  = (phase_reg == PH_AFTER_P) ? PH_NUM1 : PH_NUM2;
                    end else begin
                        ph_upd = PH_ERR;
                        if (first_err_reg == ymdp_pkg::ST_OK) begin
                            err_upd = (phase_reg == PH_AFTER_P) ? ymdp_pkg::ST_NONE
                                                                : ymdp_pkg::ST_TRAILING;
                        end
                    end
                end
                PH_NUM1: begin
                    priority if (is_digit) begin
                        num_upd = acc_new;
                        ovf_upd = acc_ovf_reg | acc_sat;
                    end else if (in_ch_reg == ymdp_pkg::CH_Y) begin
                        yrs_upd = number_acc_reg;
                        ph_upd  = PH_AFTER_Y;
                    end else if (in_ch_reg == ymdp_pkg::CH_M) begin
                        mon_upd = number_acc_reg;
                        ph_upd  = PH_DONE;
                    end else begin
                        ph_upd = PH_ERR;
                        if (first_err_reg == ymdp_pkg::ST_OK) begin
                            err_upd = ymdp_pkg::ST_BAD_UNIT;
                        end
                    end
                end
                PH_NUM2: begin
                    priority if (is_digit) begin
                        num_upd = acc_new;
                        ovf_upd = acc_ovf_reg | acc_sat;
                    end else if (in_ch_reg == ymdp_pkg::CH_M) begin
                        mon_upd = number_acc_reg;
                        ph_upd  = PH_DONE;
                    end else begin
                        ph_upd = PH_ERR;
                        if (first_err_reg == ymdp_pkg::ST_OK) begin
                            err_upd = ymdp_pkg::ST_EXPECT_M;
                        end
                    end
                end
                PH_DONE: begin
                    ph_upd = PH_ERR;
                    if (first_err_reg == ymdp_pkg::ST_OK) begin
                        err_upd = ymdp_pkg::ST_TRAILING;
                    end
                end
                PH_NOP, PH_ERR: begin
                    ph_upd = phase_reg;
                end
                default: begin
                    ph_upd = phase_reg;
                end
            endcase
        end

        // End status in priority order, from the state after this character
        priority if (ph_upd == PH_START) begin
            end_status = ymdp_pkg::ST_EMPTY;
        end else if (ph_upd == PH_SIGN || ph_upd == PH_NOP) begin
            end_status = ymdp_pkg::ST_NO_P;
        end else if (ph_upd == PH_AFTER_P) begin
            end_status = ymdp_pkg::ST_NO_COMP_P;
        end else if (t_upd) begin
            end_status = ymdp_pkg::ST_T;
        end else if (d_upd) begin
            end_status = ymdp_pkg::ST_D;
        end else if (err_upd != ymdp_pkg::ST_OK) begin
            end_status = err_upd;
        end else if (ph_upd == PH_NUM1) begin
            end_status = ymdp_pkg::ST_UNTERM;
        end else if (ph_upd == PH_NUM2) begin
            end_status = ymdp_pkg::ST_EXPECT_M;
        end else begin
            end_status = ymdp_pkg::ST_OK;
        end

        // The last item of a text returns the parser to the start of text
        if (in_is_last_reg) begin
            phase_next      = PH_START;
            sign_next       = 1'b0;
            number_acc_next = '0;
            years_acc_next  = '0;
            months_acc_next = '0;
            acc_ovf_next    = 1'b0;
            seen_t_next     = 1'b0;
            seen_d_next     = 1'b0;
            first_err_next  = ymdp_pkg::ST_OK;
        end else begin
            phase_next      = ph_upd;
            sign_next       = sign_upd;
            number_acc_next = num_upd;
            years_acc_next  = yrs_upd;
            months_acc_next = mon_upd;
            acc_ovf_next    = ovf_upd;
            seen_t_next     = t_upd;
            seen_d_next     = d_upd;
            first_err_next  = err_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            sign_reg       <= 1'b0;
            number_acc_reg <= '0;
            years_acc_reg  <= '0;
            months_acc_reg <= '0;
            acc_ovf_reg    <= 1'b0;
            seen_t_reg     <= 1'b0;
            seen_d_reg     <= 1'b0;
            first_err_reg  <= ymdp_pkg::ST_OK;
        end else if (take_item) begin
            phase_reg      <= phase_next;
            sign_reg       <= sign_next;
            number_acc_reg <= number_acc_next;
            years_acc_reg  <= years_acc_next;
            months_acc_reg <= months_acc_next;
            acc_ovf_reg    <= acc_ovf_next;
            seen_t_reg     <= seen_t_next;
            seen_d_reg     <= seen_d_next;
            first_err_reg  <= first_err_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the finished text
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
        end else if (r1_ready) begin
            r1_valid_reg <= take_item && in_is_last_reg;
        end
        if (r1_ready) begin
            r1_status_reg <= end_status;
            r1_sign_reg   <= sign_upd;
            r1_years_reg  <= yrs_upd;
            r1_months_reg <= mon_upd;
            r1_ovf_reg    <= ovf_upd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: total months and range check
    // ------------------------------------------------------------------
    assign sum_total = ({4'b0, r1_years_reg} << 3) + ({4'b0, r1_years_reg} << 2)
                     + {4'b0, r1_months_reg};

    always_comb begin
        r2_status_next = r1_status_reg;
        r2_neg_next    = 1'b0;
        r2_total_next  = '0;
        if (r1_status_reg == ymdp_pkg::ST_OK) begin
            if (r1_ovf_reg || sum_total > ymdp_pkg::MAX_TOTAL) begin
                r2_status_next = ymdp_pkg::ST_OVERFLOW;
            end else begin
                r2_total_next = sum_total[TOTAL_W-1:0];
                // Drop the sign of a zero duration
                r2_neg_next   = r1_sign_reg && (sum_total != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r2_valid_reg <= 1'b0;
        end else if (r2_ready) begin
            r2_valid_reg <= r1_valid_reg;
        end
        if (r2_ready) begin
            r2_status_reg <= r2_status_next;
            r2_neg_reg    <= r2_neg_next;
            r2_total_reg  <= r2_total_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by twelve as (total / 4) / 3 by reciprocal multiply
    // ------------------------------------------------------------------
    assign div_prod = {{(PROD_W-DIV_W){1'b0}}, r2_total_reg[TOTAL_W-1:2]}
                    * {{(PROD_W-32){1'b0}}, ymdp_pkg::RECIP_3};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r3_valid_reg <= 1'b0;
        end else if (r3_ready) begin
            r3_valid_reg <= r2_valid_reg;
        end
        if (r3_ready) begin
            r3_status_reg <= r2_status_reg;
            r3_neg_reg    <= r2_neg_reg;
            r3_total_reg  <= r2_total_reg;
            r3_quot_reg   <= div_prod[ymdp_pkg::RECIP_SHIFT +: YEAR_W];
        end
    end

    // ------------------------------------------------------------------
    // Output register: remainder from total minus quotient times twelve
    // ------------------------------------------------------------------
    assign rem_full = r3_total_reg
                    - ({{(TOTAL_W-YEAR_W){1'b0}}, r3_quot_reg} << 3)
                    - ({{(TOTAL_W-YEAR_W){1'b0}}, r3_quot_reg} << 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= r3_valid_reg;
        end
        if (out_ready) begin
            m_status_reg <= r3_status_reg;
            m_neg_reg    <= r3_neg_reg;
            m_total_reg  <= r3_total_reg;
            m_year_reg   <= r3_quot_reg;
            m_month_reg  <= rem_full[ymdp_pkg::MONTH_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_negative    = m_neg_reg;
    assign m_month_total = m_total_reg;
    assign m_year_part   = m_year_reg;
    assign m_month_part  = m_month_reg;

endmodule

@@ bench/tb_year_month_duration_parser_core.sv @@
// Self-checking testbench for the streaming year-month duration parser core.
module tb_year_month_duration_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int TARGET_ITEMS  = 600;
    localparam int REPORT_LIMIT  = 10;

    // One character item as it travels on the s_ channel
    typedef struct packed {
        logic [ymdp_pkg::CHAR_W-1:0] ch;
        logic                        has_char;
        logic                        is_last;
    } char_item_t;

    // One parsed duration as it leaves on the m_ channel
    typedef struct packed {
        ymdp_pkg::status_t              status;
        logic                           negative;
        logic [ymdp_pkg::TOTAL_W-1:0]   month_total;
        logic [ymdp_pkg::YEAR_W-1:0]    year_part;
        logic [ymdp_pkg::MONTH_W-1:0]   month_part;
    } duration_t;

    // Where the parser stands within the current text
    typedef enum logic [3:0] {
        PS_START,
        PS_MINUS,
        PS_NOT_P,
        PS_AFTER_P,
        PS_FIRST_NUM,
        PS_AFTER_Y,
        PS_MONTH_NUM,
        PS_COMPLETE,
        PS_FAILED
    } parse_phase_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [ymdp_pkg::CHAR_W-1:0]    s_ch = '0;
    logic                           s_has_char = 1'b0;
    logic                           s_is_last = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [ymdp_pkg::STATUS_W-1:0]  m_status;
    logic                           m_negative;
    logic [ymdp_pkg::TOTAL_W-1:0]   m_month_total;
    logic [ymdp_pkg::YEAR_W-1:0]    m_year_part;
    logic [ymdp_pkg::MONTH_W-1:0]   m_month_part;

    // Predictor state: a private copy of the parser's registers
    parse_phase_t                   parse_phase;
    logic                           minus_seen;
    logic [ymdp_pkg::ACC_W-1:0]     digit_acc;
    logic [ymdp_pkg::ACC_W-1:0]     year_count;
    logic [ymdp_pkg::ACC_W-1:0]     month_count;
    logic                           digit_sat;
    logic                           t_flag;
    logic                           d_flag;
    ymdp_pkg::status_t              first_fault;

    char_item_t                     pending_chars[$];
    duration_t                      expected_durations[$];
    logic [ymdp_pkg::CHAR_W-1:0]    draft[$];
    string                          syntax_chars = "-PYMTD0123456789";

    int unsigned          send_wait = 0;
    int unsigned          take_wait = 0;
    bit                   send_burst = 1'b0;
    bit                   take_burst = 1'b0;
    int unsigned          cycle_count = 0;
    int unsigned          counted_items = 0;
    int unsigned          text_count = 0;
    int unsigned          chars_accepted = 0;
    int unsigned          durations_checked = 0;
    int unsigned          mismatch_count = 0;
    logic [15:0]          status_seen = '0;

    bit                   predicted;
    duration_t            predicted_duration;
    duration_t            want_duration;
    duration_t            got_duration;

    year_month_duration_parser_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_has_char    (s_has_char),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_negative    (m_negative),
        .m_month_total (m_month_total),
        .m_year_part   (m_year_part),
        .m_month_part  (m_month_part)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return the parser to the start of text with every flag clear.
    task automatic clear_parser();
        parse_phase = PS_START;
        minus_seen  = 1'b0;
        digit_acc   = '0;
        year_count  = '0;
        month_count = '0;
        digit_sat   = 1'b0;
        t_flag      = 1'b0;
        d_flag      = 1'b0;
        first_fault = ymdp_pkg::ST_OK;
    endtask

    // Shift one decimal digit into the number, saturating at all ones.
    task automatic shift_in_digit(input logic [ymdp_pkg::CHAR_W-1:0] c);
        logic [63:0] wide;
        wide = {32'd0, digit_acc} * 64'd10 + {56'd0, c} - {56'd0, ymdp_pkg::CH_ZERO};
        if (wide > 64'hFFFF_FFFF) begin
            digit_acc = '1;
            digit_sat = 1'b1;
        end else begin
            digit_acc = wide[ymdp_pkg::ACC_W-1:0];
        end
    endtask

    // Keep only the first positional fault, then park in the failed phase.
    task automatic raise_fault(input ymdp_pkg::status_t code);
        if (first_fault == ymdp_pkg::ST_OK) first_fault = code;
        parse_phase = PS_FAILED;
    endtask

    // Advance the parser by one accepted item; emit a duration on the last one.
    task automatic parse_item(input logic [ymdp_pkg::CHAR_W-1:0] c, input logic has,
                              input logic last, output bit emit, output duration_t res);
        logic [63:0]       sum;
        ymdp_pkg::status_t st;
        bit                digit;
        emit  = 1'b0;
        res   = '0;
        digit = (c >= ymdp_pkg::CH_ZERO) && (c <= ymdp_pkg::CH_NINE);
        if (has) begin
            // T and D are only noticed once the P has gone by
            if (parse_phase >= PS_AFTER_P) begin
                if (c == ymdp_pkg::CH_T) t_flag = 1'b1;
                if (c == ymdp_pkg::CH_D) d_flag = 1'b1;
            end
            case (parse_phase)
                PS_START: begin
                    if (c == ymdp_pkg::CH_MINUS) begin
                        minus_seen  = 1'b1;
                        parse_phase = PS_MINUS;
                    end else if (c == ymdp_pkg::CH_P) begin
                        parse_phase = PS_AFTER_P;
                    end else begin
                        parse_phase = PS_NOT_P;
                    end
                end
                PS_MINUS: begin
                    parse_phase = (c == ymdp_pkg::CH_P) ? PS_AFTER_P : PS_NOT_P;
                end
                PS_AFTER_P: begin
                    if (digit) begin
                        digit_acc = '0;
                        shift_in_digit(c);
                        parse_phase = PS_FIRST_NUM;
                    end else begin
                        raise_fault(ymdp_pkg::ST_NONE);
                    end
                end
                PS_FIRST_NUM: begin
                    if (digit) begin
                        shift_in_digit(c);
                    end else if (c == ymdp_pkg::CH_Y) begin
                        year_count  = digit_acc;
                        parse_phase = PS_AFTER_Y;
                    end else if (c == ymdp_pkg::CH_M) begin
                        month_count = digit_acc;
                        parse_phase = PS_COMPLETE;
                    end else begin
                        raise_fault(ymdp_pkg::ST_BAD_UNIT);
                    end
                end
                PS_AFTER_Y: begin
                    // Only a month number may follow a year component
                    if (digit) begin
                        digit_acc = '0;
                        shift_in_digit(c);
                        parse_phase = PS_MONTH_NUM;
                    end else begin
                        raise_fault(ymdp_pkg::ST_TRAILING);
                    end
                end
                PS_MONTH_NUM: begin
                    if (digit) begin
                        shift_in_digit(c);
                    end else if (c == ymdp_pkg::CH_M) begin
                        month_count = digit_acc;
                        parse_phase = PS_COMPLETE;
                    end else begin
                        raise_fault(ymdp_pkg::ST_EXPECT_M);
                    end
                end
                PS_COMPLETE: begin
                    raise_fault(ymdp_pkg::ST_TRAILING);
                end
                default: begin
                end
            endcase
        end
        if (!last) return;

        // Status priority: empty, no P, nothing after P, T, D, first fault, unterminated, expect M
        if (parse_phase == PS_START) st = ymdp_pkg::ST_EMPTY;
        else if (parse_phase == PS_MINUS || parse_phase == PS_NOT_P) st = ymdp_pkg::ST_NO_P;
        else if (parse_phase == PS_AFTER_P) st = ymdp_pkg::ST_NO_COMP_P;
        else if (t_flag) st = ymdp_pkg::ST_T;
        else if (d_flag) st = ymdp_pkg::ST_D;
        else if (first_fault != ymdp_pkg::ST_OK) st = first_fault;
        else if (parse_phase == PS_FIRST_NUM) st = ymdp_pkg::ST_UNTERM;
        else if (parse_phase == PS_MONTH_NUM) st = ymdp_pkg::ST_EXPECT_M;
        else st = ymdp_pkg::ST_OK;

        if (st == ymdp_pkg::ST_OK) begin
            sum = {32'd0, year_count} * 64'd12 + {32'd0, month_count};
            if (digit_sat || sum > ymdp_pkg::MAX_TOTAL) begin
                st = ymdp_pkg::ST_OVERFLOW;
            end else begin
                res.month_total = sum[ymdp_pkg::TOTAL_W-1:0];
                res.year_part   = ymdp_pkg::YEAR_W'(sum / 64'd12);
                res.month_part  = ymdp_pkg::MONTH_W'(sum % 64'd12);
                // A zero total never carries a minus sign
                res.negative    = minus_seen && (sum != 64'd0);
            end
        end
        res.status = st;
        emit = 1'b1;
        clear_parser();
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Queue one item and count it towards the stimulus target.
    task automatic queue_item(input logic [ymdp_pkg::CHAR_W-1:0] c, input logic has,
                              input logic last);
        char_item_t it;
        it.ch       = c;
        it.has_char = has;
        it.is_last  = last;
        pending_chars.push_back(it);
        counted_items++;
        if (last) text_count++;
    endtask

    // Queue the characters of a literal, closing the text on the final one if asked.
    task automatic queue_text(input string s, input bit closes);
        int i;
        for (i = 0; i < s.len(); i++) begin
            queue_item(s[i], 1'b1, closes && (i == s.len() - 1));
        end
    endtask

    // Append a decimal number: mostly short, now and then long enough to saturate.
    task automatic append_number();
        int unsigned len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
        repeat (len)
            draft.push_back(ymdp_pkg::CH_ZERO + ymdp_pkg::CHAR_W'($urandom_range(0, 9)));
    endtask

    // Build one random text: mostly well-formed, some broken, some plain noise.
    task automatic queue_random_text();
        int unsigned kind;
        int unsigned form;
        int unsigned pos;
        int          i;
        bit          blank_end;
        draft.delete();
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            if ($urandom_range(0, 2) == 0) draft.push_back(ymdp_pkg::CH_MINUS);
            draft.push_back(ymdp_pkg::CH_P);
            form = $urandom_range(0, 2);
            if (form != 1) begin
                append_number();
                draft.push_back(ymdp_pkg::CH_Y);
            end
            if (form != 0) begin
                append_number();
                draft.push_back(ymdp_pkg::CH_M);
            end
            // Break roughly a quarter of the well-formed texts in one place
            if (kind >= 65) begin
                pos = $urandom_range(0, draft.size() - 1);
                case ($urandom_range(0, 3))
                    0: draft[pos] = ymdp_pkg::CHAR_W'($urandom_range(0, 255));
                    1: draft.insert(pos, syntax_chars[$urandom_range(0, syntax_chars.len() - 1)]);
                    2: draft.delete(pos);
                    default: draft = draft[0:pos];
                endcase
            end
        end else begin
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 1) == 0)
                    draft.push_back(ymdp_pkg::CHAR_W'($urandom_range(0, 255)));
                else
                    draft.push_back(syntax_chars[$urandom_range(0, syntax_chars.len() - 1)]);
            end
        end

        // Scatter empty items through the text and sometimes close on one
        blank_end = ($urandom_range(0, 9) == 0) || (draft.size() == 0);
        for (i = 0; i < draft.size(); i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_item(ymdp_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_item(draft[i], 1'b1, !blank_end && (i == draft.size() - 1));
        end
        if (blank_end) queue_item(ymdp_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued items, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_ch       <= '0;
            s_has_char <= 1'b0;
            s_is_last  <= 1'b0;
            send_wait  = 0;
            clear_parser();
        end else begin
            if (s_valid && s_ready) begin
                parse_item(s_ch, s_has_char, s_is_last, predicted, predicted_duration);
                if (predicted) expected_durations.push_back(predicted_duration);
                if (s_has_char) chars_accepted++;
                // Switch between idling and back-to-back stretches now and then
                if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
            end
            // Hold the payload while an item waits; otherwise count down the gap
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    s_ch       <= pending_chars[0].ch;
                    s_has_char <= pending_chars[0].has_char;
                    s_is_last  <= pending_chars[0].is_last;
                    s_valid    <= 1'b1;
                    void'(pending_chars.pop_front());
                    send_wait = draw_wait(send_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, compare each duration with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_duration.status      = m_status;
                got_duration.negative    = m_negative;
                got_duration.month_total = m_month_total;
                got_duration.year_part   = m_year_part;
                got_duration.month_part  = m_month_part;
                if (expected_durations.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("[%0t] duration with none expected: status %0d total %0d",
                                 $realtime, m_status, m_month_total);
                end else begin
                    want_duration = expected_durations.pop_front();
                    durations_checked++;
                    status_seen[want_duration.status] = 1'b1;
                    if (got_duration.status      !== want_duration.status      ||
                        got_duration.negative    !== want_duration.negative    ||
                        got_duration.month_total !== want_duration.month_total ||
                        got_duration.year_part   !== want_duration.year_part   ||
                        got_duration.month_part  !== want_duration.month_part) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("[%0t] duration %0d mismatch", $realtime, durations_checked);
                            $display("  expected status %0d neg %0d total %0d years %0d months %0d",
                                     want_duration.status, want_duration.negative,
                                     want_duration.month_total, want_duration.year_part,
                                     want_duration.month_part);
                            $display("  actual   status %0d neg %0d total %0d years %0d months %0d",
                                     got_duration.status, got_duration.negative,
                                     got_duration.month_total, got_duration.year_part,
                                     got_duration.month_part);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0) take_burst = ~take_burst;
                take_wait = draw_wait(take_burst);
            end else if (!m_ready && take_wait != 0) begin
                take_wait--;
            end
            m_ready <= (take_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed texts, random texts, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        // Empty text, lone sign, nothing after P, missing P
        queue_item(8'h00, 1'b0, 1'b1);
        queue_text("-", 1'b1);
        queue_text("P", 1'b1);
        queue_text("-P", 1'b1);
        queue_text("X5Y", 1'b1);
        queue_text("--P1M", 1'b1);
        // Well-formed texts, negative zero and a year-only text
        queue_text("P1Y2M", 1'b1);
        queue_text("-P0Y0M", 1'b1);
        queue_text("-P1Y11M", 1'b1);
        queue_text("P3Y", 1'b1);
        // Positional faults
        queue_text("P12", 1'b1);
        queue_text("P1Y2", 1'b1);
        queue_text("PY", 1'b1);
        queue_text("P1X", 1'b1);
        queue_text("P1YM", 1'b1);
        queue_text("P1M2M", 1'b1);
        // T and D outrank every positional fault
        queue_text("P2T", 1'b1);
        queue_text("PD", 1'b1);
        queue_text("PT1Y", 1'b1);
        // Largest total in two forms, totals just over it, saturated accumulator
        queue_text("P2147483647M", 1'b1);
        queue_text("P178956970Y7M", 1'b1);
        queue_text("P2147483648M", 1'b1);
        queue_text("P178956970Y12M", 1'b1);
        queue_text("P99999999999M", 1'b1);
        // Byte extremes and items without a character
        queue_item(8'h00, 1'b1, 1'b1);
        queue_text("P1", 1'b0);
        queue_item(8'hFF, 1'b1, 1'b1);
        queue_text("P1", 1'b0);
        queue_item(8'hA5, 1'b0, 1'b0);
        queue_text("M", 1'b1);
        queue_text("P3M", 1'b0);
        queue_item(8'hFF, 1'b0, 1'b1);

        while (counted_items < TARGET_ITEMS) queue_random_text();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last item to go in, then for every duration to come out
        while (pending_chars.size() != 0 || s_valid) @(posedge aclk);
        while (expected_durations.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Parsed %0d texts (%0d characters), %0d durations checked, %0d mismatches",
                 text_count, chars_accepted, durations_checked, mismatch_count);
        $display("Status codes reached (bit per code): %b",
                 status_seen[ymdp_pkg::ST_OVERFLOW:0]);
        if (mismatch_count == 0 && expected_durations.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Abandon a run that hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d durations outstanding",
                 cycle_count, expected_durations.size());
        $display("Verification failed");
        $finish;
    end

endmodule
